/* src/bsoe_pkg.sv */
`timescale 1ns / 1ps
package bsoe_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int RESULT_LIMIT = 32;
  localparam int ELEM_W       = 32;
  localparam int SIZE_W       = 5;
  localparam int OP_W         = 2;
  localparam int CMD_W        = 2;
  localparam int RUN_W        = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_A   = 2'd0,
    CMD_ADD_B   = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [OP_W-1:0] {
    OP_UNION     = 2'd0,
    OP_INTERSECT = 2'd1,
    OP_DIFF      = 2'd2,
    OP_SYMDIFF   = 2'd3
  } op_t;

  // One queued transaction passed from the front end to the back end.
  typedef struct packed {
    cmd_t              cmd;
    logic [ELEM_W-1:0] element;
  } item_t;

endpackage

/* src/bsoe_ram.sv */
`timescale 1ns / 1ps
module bsoe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bsoe_front.sv */
`timescale 1ns / 1ps
module bsoe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bsoe_pkg::CMD_W-1:0]   in_cmd,
  input  logic [bsoe_pkg::ELEM_W-1:0]  in_element,
  output logic                         q_valid,
  output bsoe_pkg::item_t              q_item,
  input  logic                         q_pop
);
  import bsoe_pkg::*;

  item_t      entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  item_t      new_item;

  assign in_stall = (fill_r == 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    new_item.cmd     = cmd_t'(in_cmd);
    new_item.element = in_element;
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* src/bsoe_back.sv */
`timescale 1ns / 1ps
module bsoe_back #(
  parameter int CAPACITY = bsoe_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bsoe_pkg::OP_W-1:0]    cfg_wr_data,
  input  logic                         q_valid,
  input  bsoe_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bsoe_pkg::ELEM_W-1:0]  out_result_value,
  output logic                         out_last_of_run,
  output logic                         out_result_empty,
  output logic                         out_sets_equal,
  output logic [bsoe_pkg::SIZE_W-1:0]  out_size_a,
  output logic [bsoe_pkg::SIZE_W-1:0]  out_size_b,
  output logic                         out_overflowed
);
  import bsoe_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_INS, S_ENTER,
    S_OUT_RD, S_OUT_LD, S_IN_RD, S_IN_CMP, S_DECIDE, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PH_EQ, PH_A_ALL, PH_A_NOT_B, PH_B_NOT_A, PH_B_IN_A, PH_DONE
  } phase_t;

  state_t            state_r, state_nxt;
  phase_t            ph_r, ph_nxt, ph_next;
  op_t               op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic              tgt_b_r, tgt_b_nxt;
  logic [ELEM_W-1:0] v_r, v_nxt;
  logic              found_r, found_nxt;
  logic              equal_r, equal_nxt;
  logic [ELEM_W-1:0] pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [RUN_W-1:0]  n_r, n_nxt;
  logic              ov_r, ov_nxt;
  logic [ELEM_W-1:0] ov_value_r, ov_value_nxt;
  logic              ov_last_r, ov_last_nxt;
  logic              ov_empty_r, ov_empty_nxt;
  logic              ov_equal_r, ov_equal_nxt;
  logic [SIZE_W-1:0] ov_size_a_r, ov_size_a_nxt, ov_size_b_r, ov_size_b_nxt;
  logic              ov_ovf_r, ov_ovf_nxt;

  logic              out_free;
  logic              src_is_b, want;
  logic [CNT_W-1:0]  src_n, other_n, cnt_tgt;
  logic [IDX_W-1:0]  rd_idx;
  logic [ELEM_W-1:0] rdata_a, rdata_b;
  logic              we_a, we_b;
  logic              emit;

  bsoe_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY), .AW(IDX_W)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(cnt_a_r[IDX_W-1:0]), .wdata(v_r),
    .raddr(rd_idx), .rdata(rdata_a)
  );
  bsoe_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY), .AW(IDX_W)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(cnt_b_r[IDX_W-1:0]), .wdata(v_r),
    .raddr(rd_idx), .rdata(rdata_b)
  );

  assign out_free = !ov_r || !out_stall;
  assign src_is_b = (ph_r == PH_B_NOT_A) || (ph_r == PH_B_IN_A);
  assign want     = (ph_r == PH_B_IN_A) || (ph_r == PH_EQ);
  assign src_n    = src_is_b ? cnt_b_r : cnt_a_r;
  assign other_n  = (ph_r == PH_A_ALL) ? '0 : (src_is_b ? cnt_a_r : cnt_b_r);
  assign cnt_tgt  = tgt_b_r ? cnt_b_r : cnt_a_r;
  assign we_a     = (state_r == S_INS) && !tgt_b_r && (cnt_a_r < CNT_W'(CAPACITY));
  assign we_b     = (state_r == S_INS) && tgt_b_r && (cnt_b_r < CNT_W'(CAPACITY));
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign emit     = (found_r == want) && (n_r < RUN_W'(RESULT_LIMIT));

  always_comb begin
    unique case (state_r)
      S_OUT_RD: rd_idx = i_r[IDX_W-1:0];
      default:  rd_idx = j_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    unique case (ph_r)
      PH_EQ: begin
        unique case (op_r)
          OP_UNION:     ph_next = PH_A_ALL;
          OP_INTERSECT: ph_next = PH_B_IN_A;
          default:      ph_next = PH_A_NOT_B;
        endcase
      end
      PH_A_ALL:   ph_next = PH_B_NOT_A;
      PH_A_NOT_B: ph_next = (op_r == OP_SYMDIFF) ? PH_B_NOT_A : PH_DONE;
      default:    ph_next = PH_DONE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    op_nxt        = cfg_wr_en ? op_t'(cfg_wr_data) : op_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    tgt_b_nxt     = tgt_b_r;
    v_nxt         = v_r;
    found_nxt     = found_r;
    equal_nxt     = equal_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    n_nxt         = n_r;
    ov_nxt        = ov_r && out_stall;
    ov_value_nxt  = ov_value_r;
    ov_last_nxt   = ov_last_r;
    ov_empty_nxt  = ov_empty_r;
    ov_equal_nxt  = ov_equal_r;
    ov_size_a_nxt = ov_size_a_r;
    ov_size_b_nxt = ov_size_b_r;
    ov_ovf_nxt    = ov_ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          v_nxt     = q_item.element;
          tgt_b_nxt = (q_item.cmd == CMD_ADD_B);
          j_nxt     = '0;
          unique case (q_item.cmd)
            CMD_ADD_A: state_nxt = (cnt_a_r == '0) ? S_INS : S_SCAN_RD;
            CMD_ADD_B: state_nxt = (cnt_b_r == '0) ? S_INS : S_SCAN_RD;
            CMD_CLEAR: begin
              cnt_a_nxt = '0;
              cnt_b_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            default: begin
              ph_nxt     = PH_EQ;
              equal_nxt  = (cnt_a_r == cnt_b_r);
              n_nxt      = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_ENTER;
            end
          endcase
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if ((tgt_b_r ? rdata_b : rdata_a) == v_r) begin
          state_nxt = S_IDLE;
        end else if (j_r + CNT_W'(1) == cnt_tgt) begin
          state_nxt = S_INS;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_INS: begin
        if (cnt_tgt < CNT_W'(CAPACITY)) begin
          if (tgt_b_r) cnt_b_nxt = cnt_b_r + CNT_W'(1);
          else         cnt_a_nxt = cnt_a_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_ENTER: begin
        i_nxt = '0;
        if (ph_r == PH_DONE) begin
          state_nxt = S_FINISH;
        end else if (src_n == '0 || (ph_r == PH_EQ && !equal_r)) begin
          ph_nxt = ph_next;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        v_nxt = src_is_b ? rdata_b : rdata_a;
        j_nxt = '0;
        if (other_n == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_IN_RD;
        end
      end
      S_IN_RD: state_nxt = S_IN_CMP;
      S_IN_CMP: begin
        if ((src_is_b ? rdata_a : rdata_b) == v_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else if (j_r + CNT_W'(1) == other_n) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_IN_RD;
        end
      end
      S_DECIDE: begin
        if (ph_r == PH_EQ && !found_r) begin
          equal_nxt = 1'b0;
          ph_nxt    = ph_next;
          state_nxt = S_ENTER;
        end else if (ph_r != PH_EQ && emit && pend_v_r && !out_free) begin
          state_nxt = S_DECIDE;
        end else begin
          // The held item goes out once a successor is known, so it is not last.
          if (ph_r != PH_EQ && emit) begin
            if (pend_v_r) begin
              ov_nxt        = 1'b1;
              ov_value_nxt  = pend_r;
              ov_last_nxt   = 1'b0;
              ov_empty_nxt  = 1'b0;
              ov_equal_nxt  = equal_r;
              ov_size_a_nxt = SIZE_W'(cnt_a_r);
              ov_size_b_nxt = SIZE_W'(cnt_b_r);
              ov_ovf_nxt    = ovf_r;
            end
            pend_nxt   = v_r;
            pend_v_nxt = 1'b1;
            n_nxt      = n_r + RUN_W'(1);
          end
          if (i_r + CNT_W'(1) == src_n) begin
            ph_nxt    = ph_next;
            state_nxt = S_ENTER;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          ov_nxt        = 1'b1;
          ov_value_nxt  = pend_v_r ? pend_r : '0;
          ov_last_nxt   = 1'b1;
          ov_empty_nxt  = !pend_v_r;
          ov_equal_nxt  = equal_r;
          ov_size_a_nxt = SIZE_W'(cnt_a_r);
          ov_size_b_nxt = SIZE_W'(cnt_b_r);
          ov_ovf_nxt    = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ph_r     <= PH_EQ;
      op_r     <= OP_UNION;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      op_r     <= op_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    tgt_b_r     <= tgt_b_nxt;
    v_r         <= v_nxt;
    found_r     <= found_nxt;
    equal_r     <= equal_nxt;
    pend_r      <= pend_nxt;
    n_r         <= n_nxt;
    ov_value_r  <= ov_value_nxt;
    ov_last_r   <= ov_last_nxt;
    ov_empty_r  <= ov_empty_nxt;
    ov_equal_r  <= ov_equal_nxt;
    ov_size_a_r <= ov_size_a_nxt;
    ov_size_b_r <= ov_size_b_nxt;
    ov_ovf_r    <= ov_ovf_nxt;
  end

  // Sizes and flags travel with each result, as later transactions may change
  // them while the result waits to be taken.
  assign out_valid        = ov_r;
  assign out_result_value = ov_value_r;
  assign out_last_of_run  = ov_last_r;
  assign out_result_empty = ov_empty_r;
  assign out_sets_equal   = ov_equal_r;
  assign out_size_a       = ov_size_a_r;
  assign out_size_b       = ov_size_b_r;
  assign out_overflowed   = ov_ovf_r;

endmodule

/* src/bounded_set_operation_engine.sv */
`timescale 1ns / 1ps
// Two sets of up to CAPACITY distinct 32-bit elements are built from add
// transactions, and a compute transaction emits the union, intersection,
// difference or symmetric difference selected by the operation register as a
// run of result transactions. Each set lives in a RAM with one write port and
// one read port, and one comparator does all searching: an add scans its
// target store for the element, and a compute makes one pass over the stores
// per phase, up to three passes, the first being the equality check. A
// two-entry queue in front takes transactions while the search runs, and the
// output register lets work go on while a result waits to be taken.
module bounded_set_operation_engine #(
  parameter int CAPACITY = bsoe_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bsoe_pkg::OP_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bsoe_pkg::CMD_W-1:0]   in_cmd,
  input  logic signed [bsoe_pkg::ELEM_W-1:0] in_element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [bsoe_pkg::ELEM_W-1:0] out_result_value,
  output logic                         out_last_of_run,
  output logic                         out_result_empty,
  output logic                         out_sets_equal,
  output logic [bsoe_pkg::SIZE_W-1:0]  out_size_a,
  output logic [bsoe_pkg::SIZE_W-1:0]  out_size_b,
  output logic                         out_overflowed
);
  import bsoe_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  bsoe_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_element(in_element),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  bsoe_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value),
    .out_last_of_run(out_last_of_run),
    .out_result_empty(out_result_empty),
    .out_sets_equal(out_sets_equal),
    .out_size_a(out_size_a), .out_size_b(out_size_b),
    .out_overflowed(out_overflowed)
  );

endmodule

/* src/bsoe_checker.sv */
`timescale 1ns / 1ps
module bsoe_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bsoe_pkg::ELEM_W-1:0]  out_result_value,
  input logic                         out_last_of_run,
  input logic                         out_result_empty,
  input logic                         out_sets_equal,
  input logic [bsoe_pkg::SIZE_W-1:0]  out_size_a,
  input logic [bsoe_pkg::SIZE_W-1:0]  out_size_b
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value))
    else $error("result changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_empty |-> out_last_of_run)
    else $error("empty result not marked last");

  a_equal_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sets_equal |-> out_size_a == out_size_b)
    else $error("equal sets with different sizes");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind bounded_set_operation_engine bsoe_checker u_bsoe_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_result_value(out_result_value), .out_last_of_run(out_last_of_run),
  .out_result_empty(out_result_empty), .out_sets_equal(out_sets_equal),
  .out_size_a(out_size_a), .out_size_b(out_size_b)
);
